@@ rtl/atu_pkg.sv @@
package atu_pkg;

  localparam int WordBits = 32;
  localparam int FracBits = 16;
  localparam int ProdBits = 2 * WordBits;
  localparam int AccBits  = ProdBits + 4;
  localparam int NumElem  = 12;

  typedef logic signed [WordBits-1:0] word_t;
  typedef logic signed [AccBits-1:0]  acc_t;

  typedef enum logic [2:0] {
    KIND_WR_CUR  = 3'd0,
    KIND_WR_OPD  = 3'd1,
    KIND_POST    = 3'd2,
    KIND_PRE     = 3'd3,
    KIND_POINT   = 3'd4,
    KIND_DIR     = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_ADD_T,
    ST_WEIGHT,
    ST_STORE,
    ST_COPY,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic clear;
    logic mac;
    logic add;
  } mac_ctrl_t;

  function automatic word_t sat_word(input acc_t x, output logic clip);
    acc_t maxv;
    acc_t minv;
    maxv = acc_t'({1'b0, {(WordBits-1){1'b1}}});
    minv = -maxv - acc_t'(1);
    clip = 1'b0;
    if (x > maxv) begin
      clip = 1'b1;
      return word_t'(maxv);
    end else if (x < minv) begin
      clip = 1'b1;
      return word_t'(minv);
    end
    return word_t'(x);
  endfunction

endpackage

@@ rtl/atu_mac.sv @@
module atu_mac (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  atu_pkg::mac_ctrl_t ctrl_i,
  input  atu_pkg::word_t    a_i,
  input  atu_pkg::word_t    b_i,
  output atu_pkg::acc_t     acc_o
);
  import atu_pkg::*;

  logic signed [ProdBits-1:0] prod;
  acc_t acc_q, acc_d, term;

  assign prod = a_i * b_i;

  // A clear together with a multiply starts a fresh sum from the new product.
  always_comb begin
    term = ctrl_i.mac ? acc_t'(prod >>> FracBits) : acc_t'(a_i);
    acc_d = acc_q;
    if (ctrl_i.clear) acc_d = ctrl_i.mac ? term : '0;
    else if (ctrl_i.mac || ctrl_i.add) acc_d = acc_q + term;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) acc_q <= '0;
    else acc_q <= acc_d;
  end

  assign acc_o = acc_q;
endmodule

@@ rtl/affine_transform_unit.sv @@
// Writes are stored when accepted. A point transform runs, per row, three
// multiply-accumulates, a translation add, a weight product and a store, and a
// direction the same but without the translation add; then the result is raised.
// All of it runs on one shared multiply-accumulate unit.
// A compose works through twelve elements and then copies the result back.
// Throughput: one item at a time; in_ready_o is low while busy or a result waits.
// Reset: asynchronous, active low; both matrices return to identity.
module affine_transform_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           kind_i,
  input  logic [3:0]           element_index_i,
  input  atu_pkg::word_t       element_value_i,
  input  atu_pkg::word_t       in_x_i,
  input  atu_pkg::word_t       in_y_i,
  input  atu_pkg::word_t       in_z_i,
  input  atu_pkg::word_t       weight_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output atu_pkg::word_t       out_x_o,
  output atu_pkg::word_t       out_y_o,
  output atu_pkg::word_t       out_z_o,
  output logic                 saturated_o
);
  import atu_pkg::*;

  state_e state_q, state_d;
  word_t cur_q [NumElem];
  word_t opd_q [NumElem];
  word_t res_q [NumElem];
  word_t vec_q [3];
  word_t wgt_q;
  logic [2:0] kind_q;
  logic [1:0] row_q, col_q, k_q;
  logic clip_q;
  word_t ox_q, oy_q, oz_q;
  logic ov_q;

  mac_ctrl_t ctrl;
  word_t a, b, sat_v;
  acc_t acc;
  logic sat_c;
  logic is_xf, is_cmp, with_t, last_k, accept;

  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE) && !ov_q;
  assign is_xf = (kind_q == KIND_POINT) || (kind_q == KIND_DIR);
  assign is_cmp = (kind_q == KIND_POST) || (kind_q == KIND_PRE);
  assign with_t = is_xf ? (kind_q == KIND_POINT) : (col_q == 2'd3);
  assign last_k = (k_q == 2'd2);

  always_comb begin
    sat_v = sat_word(acc, sat_c);
  end

  // Operands for the shared unit: element products, translation and weight.
  always_comb begin
    a = '0;
    b = '0;
    if (state_q == ST_MAC) begin
      if (is_xf) begin
        a = cur_q[4'(k_q) * 4'd3 + 4'(row_q)];
        b = vec_q[k_q];
      end else if (kind_q == KIND_POST) begin
        a = cur_q[4'(k_q) * 4'd3 + 4'(row_q)];
        b = opd_q[4'(col_q) * 4'd3 + 4'(k_q)];
      end else begin
        a = opd_q[4'(k_q) * 4'd3 + 4'(row_q)];
        b = cur_q[4'(col_q) * 4'd3 + 4'(k_q)];
      end
    end else if (state_q == ST_ADD_T) begin
      a = (is_xf || kind_q == KIND_POST) ? cur_q[4'd9 + 4'(row_q)]
                                         : opd_q[4'd9 + 4'(row_q)];
    end else if (state_q == ST_WEIGHT) begin
      a = sat_v;
      b = wgt_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (kind_i == KIND_POST || kind_i == KIND_PRE ||
                       kind_i == KIND_POINT || kind_i == KIND_DIR)) begin
          state_d = ST_MAC;
        end
      end
      ST_MAC:    if (last_k) state_d = with_t ? ST_ADD_T : (is_xf ? ST_WEIGHT : ST_STORE);
      ST_ADD_T:  state_d = is_xf ? ST_WEIGHT : ST_STORE;
      ST_WEIGHT: state_d = ST_STORE;
      ST_STORE: begin
        if (row_q != 2'd2) state_d = ST_MAC;
        else if (is_xf) state_d = ST_OUT;
        else if (col_q != 2'd3) state_d = ST_MAC;
        else state_d = ST_COPY;
      end
      ST_COPY:   state_d = ST_IDLE;
      ST_OUT:    state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    unique case (state_q)
      ST_IDLE:   ctrl.clear = 1'b1;
      ST_MAC:    ctrl.mac = 1'b1;
      ST_ADD_T:  ctrl.add = 1'b1;
      // The weight product replaces the row sum, so the accumulator restarts.
      ST_WEIGHT: begin
        ctrl.clear = 1'b1;
        ctrl.mac = 1'b1;
      end
      ST_STORE:  ctrl.clear = 1'b1;
      default:   ctrl.clear = 1'b1;
    endcase
  end

  atu_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .a_i    (a),
    .b_i    (b),
    .acc_o  (acc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q    <= 1'b0;
      row_q   <= '0;
      col_q   <= '0;
      k_q     <= '0;
      clip_q  <= 1'b0;
      kind_q  <= '0;
      ox_q    <= '0;
      oy_q    <= '0;
      oz_q    <= '0;
      for (int i = 0; i < NumElem; i++) begin
        cur_q[i] <= (i == 0 || i == 4 || i == 8) ? word_t'(1 << FracBits) : '0;
        opd_q[i] <= (i == 0 || i == 4 || i == 8) ? word_t'(1 << FracBits) : '0;
        res_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (out_valid_o && out_ready_i) ov_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            kind_q <= kind_i;
            row_q  <= '0;
            col_q  <= '0;
            k_q    <= '0;
            clip_q <= 1'b0;
            if (element_index_i < 4'd12) begin
              if (kind_i == KIND_WR_CUR) cur_q[element_index_i] <= element_value_i;
              if (kind_i == KIND_WR_OPD) opd_q[element_index_i] <= element_value_i;
            end
          end
        end
        ST_MAC: k_q <= last_k ? 2'd0 : k_q + 2'd1;
        ST_WEIGHT: clip_q <= clip_q | sat_c;
        ST_STORE: begin
          clip_q <= clip_q | sat_c;
          if (is_xf) begin
            unique case (row_q)
              2'd0:    ox_q <= sat_v;
              2'd1:    oy_q <= sat_v;
              default: oz_q <= sat_v;
            endcase
          end else begin
            res_q[4'(col_q) * 4'd3 + 4'(row_q)] <= sat_v;
          end
          if (row_q == 2'd2) begin
            row_q <= '0;
            col_q <= col_q + 2'd1;
          end else begin
            row_q <= row_q + 2'd1;
          end
        end
        ST_COPY: begin
          for (int i = 0; i < NumElem; i++) cur_q[i] <= res_q[i];
        end
        ST_OUT: ov_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      vec_q[0] <= in_x_i;
      vec_q[1] <= in_y_i;
      vec_q[2] <= in_z_i;
      wgt_q    <= weight_i;
    end
  end

  assign out_valid_o = ov_q;
  assign out_x_o = ox_q;
  assign out_y_o = oy_q;
  assign out_z_o = oz_q;
  assign saturated_o = clip_q;
  logic unused_cmp;
  assign unused_cmp = is_cmp;
endmodule

@@ rtl/atu_checker.sv @@
module atu_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic saturated_o
);
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input taken while result pending");
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  a_sat_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(saturated_o)) else $error("flag moved");
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> !out_valid_o) else $error("result repeated");
endmodule

bind affine_transform_unit atu_checker u_atu_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .saturated_o(saturated_o)
);
